>>> hw/rtl/itda_pkg.sv
// Shared constants and types for the integer to decimal text converter.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int DIGITS     = (VALUE_BITS * 301) / 1000 + 1;
    localparam int BCD_W      = DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [VALUE_BITS-1:0] mag_t;

endpackage

>>> hw/rtl/itda_if.sv
// Valid/ready channels for the integer input word and the character output word.
`timescale 1ns / 1ps

interface itda_in_if;
    import itda_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface itda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink (input valid, input char_code, input last, output ready);
endinterface

>>> hw/rtl/itda_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD conversion.
`timescale 1ns / 1ps

module itda_dabble_step
    import itda_pkg::*;
(
    input  bcd_t bcd_in,
    input  logic bit_in,
    output bcd_t bcd_out
);

    bcd_t adjusted;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_in[i*4 +: 4] >= 4'd5)
            begin
                adjusted[i*4 +: 4] = bcd_in[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adjusted[i*4 +: 4] = bcd_in[i*4 +: 4];
            end
        end
    end

    assign bcd_out = {adjusted[BCD_W-2:0], bit_in};

endmodule

>>> hw/rtl/int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

// Each accepted word holds a signed integer, and the block sends its decimal text one
// character per output word, most significant first, with a leading '-' for negative
// values, no leading zeros, and last set on the final digit. One shift-and-add-3 unit
// converts the magnitude one bit per cycle. An item passes through taking the word, the
// conversion, a skip step for each leading zero that is dropped and a final skip step,
// and the sending of each character. The dropped zeros and the digits always add up to
// ten, and while a character cannot be sent the block waits.
// Input ready is high only while no item is in work; the output register lets the final
// character wait while the next word is taken.

module int_to_decimal_ascii
    import itda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    itda_in_if.sink     num,
    itda_out_if.source  chars
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 ov_reg, ov_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 neg_reg, neg_next;
    mag_t                 shift_reg, shift_next;
    bcd_t                 bcd_reg, bcd_next;
    bcd_t                 bcd_step;
    logic [BIT_CNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [DIG_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [3:0]           top_digit;
    logic                 out_free;
    mag_t                 raw;

    itda_dabble_step u_step (
        .bcd_in  (bcd_reg),
        .bit_in  (shift_reg[VALUE_BITS-1]),
        .bcd_out (bcd_step)
    );

    assign top_digit   = bcd_reg[BCD_W-1 -: 4];
    assign out_free    = !ov_reg || chars.ready;
    assign raw         = num.value;
    assign num.ready   = (state_reg == ST_IDLE);
    assign chars.valid = ov_reg;
    assign chars.char_code = char_reg;
    assign chars.last  = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        ov_next     = ov_reg && !chars.ready;
        char_next   = char_reg;
        last_next   = last_reg;
        neg_next    = neg_reg;
        shift_next  = shift_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        dcnt_next   = dcnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (num.valid)
                begin
                    neg_next    = raw[VALUE_BITS-1];
                    shift_next  = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    bcd_next    = '0;
                    bitcnt_next = '0;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next    = bcd_step;
                shift_next  = {shift_reg[VALUE_BITS-2:0], 1'b0};
                bitcnt_next = bitcnt_reg + 1'b1;
                if (bitcnt_reg == BIT_CNT_W'(VALUE_BITS - 1))
                begin
                    dcnt_next  = DIG_CNT_W'(DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && dcnt_reg != DIG_CNT_W'(1))
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (neg_reg)
                    begin
                        char_next = ASCII_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        char_next = ASCII_ZERO + {4'd0, top_digit};
                        last_next = (dcnt_reg == DIG_CNT_W'(1));
                        bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                        dcnt_next = dcnt_reg - 1'b1;
                        if (dcnt_reg == DIG_CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        last_reg   <= last_next;
        neg_reg    <= neg_next;
        shift_reg  <= shift_next;
        bcd_reg    <= bcd_next;
        bitcnt_reg <= bitcnt_next;
        dcnt_reg   <= dcnt_next;
    end

`ifndef SYNTHESIS
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid |-> (chars.char_code == ASCII_MINUS ||
                         (chars.char_code >= ASCII_ZERO &&
                          chars.char_code <= ASCII_ZERO + 8'd9)))
        else $error("Output character is neither a digit nor a minus sign.");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.char_code == ASCII_MINUS) |-> !chars.last)
        else $error("Minus sign flagged as the final character.");

    a_dcnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> dcnt_reg != '0)
        else $error("Digit count reached zero while sending text.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (num.valid && num.ready) |=> (!num.ready && state_reg == ST_CONV))
        else $error("Converter did not start after taking a word.");

    a_hold_unless_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && !chars.ready) |=> (chars.valid && $stable(chars.char_code)))
        else $error("Pending character changed before it was taken.");
`endif

endmodule

>>> tb/tb_int_to_decimal_ascii.sv
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii;
    import itda_pkg::*;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } char_word_t;

    logic clk;
    logic rst_n;

    itda_in_if  num_if ();
    itda_out_if chars_if ();

    int_to_decimal_ascii dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if),
        .chars (chars_if)
    );

    char_word_t pending_chars[$];
    int         mismatch_count = 0;
    bit         sender_idling = 1'b0;
    bit         receiver_idling = 1'b0;
    int         hold_left = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Expected text of one integer: optional minus sign, then digits, last on the final digit.
    function automatic void queue_text(input logic signed [VALUE_BITS-1:0] v);
        logic [7:0] digit_buf [0:DIGITS-1];
        mag_t       mag;
        bit         negative;
        int         nd;
        char_word_t w;
        negative = v[VALUE_BITS-1];
        mag = negative ? (~mag_t'(v) + 1'b1) : mag_t'(v);
        nd = 0;
        do
        begin
            digit_buf[nd] = ASCII_ZERO + 8'(mag % 10);
            nd++;
            mag = mag / 10;
        end
        while (mag != 0);
        if (negative)
        begin
            w.char_code = ASCII_MINUS;
            w.last = 1'b0;
            pending_chars.push_back(w);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            w.char_code = digit_buf[k];
            w.last = (k == 0);
            pending_chars.push_back(w);
        end
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        case ($urandom_range(0, 3))
            0: return $urandom;
            3:
            begin
                case ($urandom_range(0, 2))
                    0: return 32'sh80000000 + $urandom_range(0, 20);
                    1: return 2147483647 - $urandom_range(0, 20);
                    default: return $urandom_range(0, 40) - 20;
                endcase
            end
            default:
            begin
                n = $urandom_range(1, 10);
                lo = 1;
                for (int i = 1; i < n; i++)
                    lo = lo * 10;
                hi = lo * 10 - 1;
                if (n == 1)
                    lo = 0;
                if (hi > 64'sd2147483647)
                    hi = 64'sd2147483647;
                mag = lo + longint'({32'b0, $urandom}) % (hi - lo + 1);
                if ($urandom_range(0, 1))
                    mag = -mag;
                return mag[VALUE_BITS-1:0];
            end
        endcase
    endfunction

    task automatic send_word(input logic signed [VALUE_BITS-1:0] v);
        int gap;
        @(negedge clk);
        if (sender_idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            num_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        num_if.valid <= 1'b1;
        num_if.value <= v;
        do
            @(posedge clk);
        while (!num_if.ready);
        queue_text(v);
    endtask

    task automatic wait_text_drained();
        @(negedge clk);
        num_if.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Output side: always ready, random stall bursts when receiver_idling is set, or a long hold when one is requested.
    initial
    begin
        int burst;
        burst = 0;
        chars_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                chars_if.ready <= 1'b0;
                hold_left--;
            end
            else if (!receiver_idling)
                chars_if.ready <= 1'b1;
            else if (burst > 0)
            begin
                chars_if.ready <= 1'b0;
                burst--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 14) - 1;
                chars_if.ready <= 1'b0;
            end
            else
                chars_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_word
        char_word_t want;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected char 0x%02h last %0d",
                                          chars_if.char_code, chars_if.last));
            else
            begin
                want = pending_chars.pop_front();
                if (chars_if.char_code !== want.char_code)
                    report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                              chars_if.char_code, want.char_code));
                if (chars_if.last !== want.last)
                    report_mismatch($sformatf("last %0d, expected %0d",
                                              chars_if.last, want.last));
            end
        end
    end

    task automatic test_directed_values();
        logic signed [VALUE_BITS-1:0] vals[$];
        vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647, 32'sh80000000,
                 -2147483647, 2147483646, 1000000000, -1000000000, 999999999,
                 -999999999, 1234567890, -1234567890, 32'h55555555, 32'hAAAAAAAA};
        sender_idling = 1'b0;
        receiver_idling = 1'b0;
        foreach (vals[i])
            send_word(vals[i]);
        wait_text_drained();
    endtask

    task automatic test_random_values(input int count);
        sender_idling = 1'b1;
        receiver_idling = 1'b1;
        repeat (count)
            send_word(random_value());
    endtask

    // The output is held off while the input keeps offering words.
    task automatic test_output_hold();
        sender_idling = 1'b0;
        receiver_idling = 1'b0;
        hold_left = 400;
        repeat (8)
            send_word(random_value());
        wait_text_drained();
    endtask

    task automatic test_drain_pause();
        sender_idling = 1'b1;
        receiver_idling = 1'b1;
        repeat (3)
        begin
            repeat (7)
                send_word(random_value());
            wait_text_drained();
        end
    endtask

    task automatic test_full_rate(input int count);
        sender_idling = 1'b0;
        receiver_idling = 1'b0;
        repeat (count)
            send_word(random_value());
        wait_text_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        num_if.valid = 1'b0;
        num_if.value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_values();
        test_random_values(200);
        test_output_hold();
        test_drain_pause();
        test_random_values(180);
        test_full_rate(40);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/itda_pkg.sv
hw/rtl/itda_if.sv
hw/rtl/itda_dabble_step.sv
hw/rtl/int_to_decimal_ascii.sv
tb/tb_int_to_decimal_ascii.sv
